// ===== sv/mqf_pkg.sv =====
// Package for the multi-queue FIFO: command and status codes, controller states
// and the request and result payload structs. It depends on nothing else.
`default_nettype none

package mqf_pkg;

  // Command codes carried in a request. Code three has no meaning and is dropped.
  typedef enum logic [1:0] {
    CMD_ENQ = 2'd0,
    CMD_DEQ = 2'd1,
    CMD_LEN = 2'd2
  } cmd_e;

  // Status codes reported with every result.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_BADID = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_PTR  = 2'd1,
    S_DATA = 2'd2,
    S_LEN  = 2'd3
  } state_e;

  // Fixed field widths of the request and result payloads.
  localparam int unsigned CmdW  = 2;
  localparam int unsigned QidW  = 3;
  localparam int unsigned DataW = 64;
  localparam int unsigned LenW  = 5;

  // One request.
  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [QidW-1:0]  queue_id;
    logic [DataW-1:0] entry_data;
    logic             entry_urgent;
  } req_t;

  // One result.
  typedef struct packed {
    logic [1:0]       status;
    logic [QidW-1:0]  out_queue;
    logic [DataW-1:0] out_data;
    logic             out_urgent;
    logic [LenW-1:0]  queue_length;
    logic             last;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/mqf_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; it uses no package.
`default_nettype none

module mqf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire                     re_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/multi_queue_fifo.sv =====
// Multi-queue FIFO: NUM_QUEUES circular queues in one shared entry RAM, with the
// head pointer and fill count of each queue kept in a small pointer RAM.
// Depends on mqf_pkg and mqf_ram.
//
// Enqueue: pointer read, then the entry write (unless full) and result in S_PTR;
// busy in S_PTR. Dequeue: pointer read, then entry read in S_DATA; busy in S_PTR
// and S_DATA, an empty queue answers from S_PTR. Bad queue id: result in the
// cycle after start, never busy. Length report: one pointer RAM read per queue,
// NUM_QUEUES results on consecutive cycles from S_LEN. The receiver cannot stall.
// Reset (asynchronous, active low) empties every queue at once through per-queue
// valid bits on the pointer RAM; the entry RAM is not cleared.
`default_nettype none

module multi_queue_fifo #(
  parameter int unsigned NUM_QUEUES  = 4,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start,
  output logic             busy,
  input  mqf_pkg::req_t    req_i,
  output logic             res_strobe_o,
  output mqf_pkg::res_t    res_o
);

  localparam int unsigned QW = $clog2(NUM_QUEUES);
  localparam int unsigned HW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned PW = HW + CW;
  localparam int unsigned EW = mqf_pkg::DataW + 1;
  localparam int unsigned ED = NUM_QUEUES * QUEUE_DEPTH;
  localparam int unsigned AW = $clog2(ED);

  // Control state.
  mqf_pkg::state_e      state_q, state_d;
  logic [QW-1:0]        cnt_q, cnt_d;
  logic [NUM_QUEUES-1:0] vld_q, vld_d;
  logic [QW-1:0]        ptr_raddr_q;
  logic                 res_strobe_q, res_strobe_d;

  // Payload registers.
  logic [mqf_pkg::CmdW-1:0]  cmd_q;
  logic [mqf_pkg::QidW-1:0]  qid_q;
  logic [mqf_pkg::DataW-1:0] data_q;
  logic                      urg_q;
  logic [CW-1:0]             len_q, len_d;
  mqf_pkg::res_t             res_q, res_d;

  // RAM ports.
  logic          ptr_re, ptr_we;
  logic [QW-1:0] ptr_raddr;
  logic [PW-1:0] ptr_wdata, ptr_rdata;
  logic          ent_re, ent_we;
  logic [AW-1:0] ent_raddr, ent_waddr;
  logic [EW-1:0] ent_rdata;

  // Decoded pointer entry and derived values.
  logic          accept;
  logic          qid_ok;
  logic [QW-1:0] q_idx;
  logic          rd_vld;
  logic [HW-1:0] head_rd;
  logic [CW-1:0] occ_rd;
  logic [SW-1:0] tail_sum;
  logic [HW-1:0] tail_slot;
  logic [HW-1:0] head_next;
  logic [AW-1:0] q_base;
  logic          len_last;

  assign accept = start && !busy;
  assign qid_ok = (4'(req_i.queue_id) < 4'(NUM_QUEUES));
  assign q_idx  = QW'(qid_q);

  // Pointer entries that were never written since reset read as an empty queue.
  assign rd_vld  = vld_q[ptr_raddr_q];
  assign head_rd = rd_vld ? ptr_rdata[PW-1:CW] : '0;
  assign occ_rd  = rd_vld ? ptr_rdata[CW-1:0] : '0;

  // Tail slot is head plus count, wrapped once at the queue depth.
  assign tail_sum  = SW'(head_rd) + SW'(occ_rd);
  assign tail_slot = (tail_sum >= SW'(QUEUE_DEPTH)) ? HW'(tail_sum - SW'(QUEUE_DEPTH))
                                                    : HW'(tail_sum);
  assign head_next = (head_rd == HW'(QUEUE_DEPTH - 1)) ? '0 : HW'(head_rd + 1'b1);
  assign q_base    = AW'(AW'(q_idx) * AW'(QUEUE_DEPTH));
  assign len_last  = (cnt_q == QW'(NUM_QUEUES - 1));

  // Head pointer and fill count of every queue.
  mqf_ram #(
    .Width(PW),
    .Depth(NUM_QUEUES)
  ) u_ptr_ram (
    .clk_i  (clk_i),
    .we_i   (ptr_we),
    .waddr_i(q_idx),
    .wdata_i(ptr_wdata),
    .re_i   (ptr_re),
    .raddr_i(ptr_raddr),
    .rdata_o(ptr_rdata)
  );

  // Data word and urgent bit of every entry.
  mqf_ram #(
    .Width(EW),
    .Depth(ED)
  ) u_ent_ram (
    .clk_i  (clk_i),
    .we_i   (ent_we),
    .waddr_i(ent_waddr),
    .wdata_i({data_q, urg_q}),
    .re_i   (ent_re),
    .raddr_i(ent_raddr),
    .rdata_o(ent_rdata)
  );

  // Next state, RAM accesses and result.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    vld_d        = vld_q;
    len_d        = len_q;
    res_strobe_d = 1'b0;
    res_d        = '0;
    ptr_re       = 1'b0;
    ptr_raddr    = '0;
    ptr_we       = 1'b0;
    ptr_wdata    = '0;
    ent_re       = 1'b0;
    ent_raddr    = '0;
    ent_we       = 1'b0;
    ent_waddr    = '0;

    unique case (state_q)
      mqf_pkg::S_IDLE: begin
        if (accept) begin
          unique case (mqf_pkg::cmd_e'(req_i.command))
            mqf_pkg::CMD_LEN: begin
              ptr_re    = 1'b1;
              ptr_raddr = '0;
              cnt_d     = '0;
              state_d   = mqf_pkg::S_LEN;
            end
            mqf_pkg::CMD_ENQ, mqf_pkg::CMD_DEQ: begin
              if (qid_ok) begin
                ptr_re    = 1'b1;
                ptr_raddr = QW'(req_i.queue_id);
                state_d   = mqf_pkg::S_PTR;
              end else begin
                res_strobe_d    = 1'b1;
                res_d.status    = mqf_pkg::ST_BADID;
                res_d.out_queue = req_i.queue_id;
                res_d.last      = 1'b1;
              end
            end
            default: begin
              // The unused command code is dropped without a result.
            end
          endcase
        end
      end

      mqf_pkg::S_PTR: begin
        res_d.out_queue = qid_q;
        res_d.last      = 1'b1;
        if (mqf_pkg::cmd_e'(cmd_q) == mqf_pkg::CMD_ENQ) begin
          // Enqueue: append at the tail unless the queue is full.
          res_strobe_d = 1'b1;
          state_d      = mqf_pkg::S_IDLE;
          if (occ_rd >= CW'(QUEUE_DEPTH)) begin
            res_d.status       = mqf_pkg::ST_FULL;
            res_d.queue_length = mqf_pkg::LenW'(occ_rd);
          end else begin
            ent_we             = 1'b1;
            ent_waddr          = q_base + AW'(tail_slot);
            ptr_we             = 1'b1;
            ptr_wdata          = {head_rd, CW'(occ_rd + 1'b1)};
            vld_d[q_idx]       = 1'b1;
            res_d.status       = mqf_pkg::ST_OK;
            res_d.queue_length = mqf_pkg::LenW'(CW'(occ_rd + 1'b1));
          end
        end else begin
          // Dequeue: read the head entry and advance the head pointer.
          if (occ_rd == '0) begin
            res_strobe_d = 1'b1;
            res_d.status = mqf_pkg::ST_EMPTY;
            state_d      = mqf_pkg::S_IDLE;
          end else begin
            ent_re       = 1'b1;
            ent_raddr    = q_base + AW'(head_rd);
            ptr_we       = 1'b1;
            ptr_wdata    = {head_next, CW'(occ_rd - 1'b1)};
            vld_d[q_idx] = 1'b1;
            len_d        = CW'(occ_rd - 1'b1);
            state_d      = mqf_pkg::S_DATA;
          end
        end
      end

      mqf_pkg::S_DATA: begin
        // The head entry read last cycle goes out with the new count.
        res_strobe_d       = 1'b1;
        res_d.status       = mqf_pkg::ST_OK;
        res_d.out_queue    = qid_q;
        res_d.out_data     = ent_rdata[EW-1:1];
        res_d.out_urgent   = ent_rdata[0];
        res_d.queue_length = mqf_pkg::LenW'(len_q);
        res_d.last         = 1'b1;
        state_d            = mqf_pkg::S_IDLE;
      end

      mqf_pkg::S_LEN: begin
        // One queue per cycle; the next pointer entry is read meanwhile.
        res_strobe_d       = 1'b1;
        res_d.status       = mqf_pkg::ST_OK;
        res_d.out_queue    = mqf_pkg::QidW'(cnt_q);
        res_d.queue_length = mqf_pkg::LenW'(occ_rd);
        res_d.last         = len_last;
        if (len_last) begin
          state_d = mqf_pkg::S_IDLE;
        end else begin
          ptr_re    = 1'b1;
          ptr_raddr = QW'(cnt_q + 1'b1);
          cnt_d     = QW'(cnt_q + 1'b1);
        end
      end

      default: begin
        state_d = mqf_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mqf_pkg::S_IDLE;
      cnt_q        <= '0;
      vld_q        <= '0;
      ptr_raddr_q  <= '0;
      res_strobe_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      vld_q        <= vld_d;
      res_strobe_q <= res_strobe_d;
      if (ptr_re) begin
        ptr_raddr_q <= ptr_raddr;
      end
    end
  end

  // Payload registers: the accepted request and the outgoing result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= req_i.command;
      qid_q  <= req_i.queue_id;
      data_q <= req_i.entry_data;
      urg_q  <= req_i.entry_urgent;
    end
    len_q <= len_d;
    res_q <= res_d;
  end

  assign busy         = (state_q != mqf_pkg::S_IDLE);
  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

  // A valid enqueue or dequeue request always moves to the pointer read state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && qid_ok && (req_i.command == mqf_pkg::CMD_ENQ ||
                          req_i.command == mqf_pkg::CMD_DEQ))
    |=> state_q == mqf_pkg::S_PTR)
    else $error("valid queue request did not start a pointer read");

  // The entry RAM is written only while a pointer entry is being evaluated.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent_we |-> state_q == mqf_pkg::S_PTR)
    else $error("entry write outside pointer state");

  // A stored fill count never exceeds the queue depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mqf_pkg::S_PTR |-> occ_rd <= CW'(QUEUE_DEPTH))
    else $error("queue fill count above depth");

  // The entry read state always yields a successful dequeue result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mqf_pkg::S_DATA |=> res_strobe_o && res_o.status == mqf_pkg::ST_OK &&
                                   res_o.last)
    else $error("dequeue result missing");

  // The final queue of a length report ends the report with last set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mqf_pkg::S_LEN && len_last) |=> res_strobe_o && res_o.last &&
                                                state_q == mqf_pkg::S_IDLE)
    else $error("length report did not end with last");

endmodule

`default_nettype wire

// ===== tb/multi_queue_fifo_checker.sv =====
// Scoreboard for the multi-queue FIFO. It tracks each queue's contents, works out
// the results of every accepted request and compares them in order.
// Depends on mqf_pkg.
`timescale 1ns / 1ps

module multi_queue_fifo_checker #(
  parameter int unsigned NUM_QUEUES  = 4,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           start_i,
  input  wire           busy_i,
  input  mqf_pkg::req_t req_i,
  input  wire           res_strobe_i,
  input  mqf_pkg::res_t res_i,
  output int            fail_count_o,
  output int            outstanding_o
);

  localparam int unsigned Slots = NUM_QUEUES * QUEUE_DEPTH;

  // Mirror of the queue contents and of each queue's head and fill level.
  logic [mqf_pkg::DataW-1:0] data_mirror   [Slots];
  logic                      urgent_mirror [Slots];
  int unsigned               head_mirror   [NUM_QUEUES];
  int unsigned               fill_mirror   [NUM_QUEUES];

  // Results still owed by the block, oldest first.
  mqf_pkg::res_t owed_results [$];

  function automatic mqf_pkg::res_t make_result(logic [1:0] st, int unsigned q,
                                                logic [mqf_pkg::DataW-1:0] d, logic u,
                                                int unsigned fill, logic is_last);
    mqf_pkg::res_t r;
    r.status       = st;
    r.out_queue    = q[mqf_pkg::QidW-1:0];
    r.out_data     = d;
    r.out_urgent   = u;
    r.queue_length = fill[mqf_pkg::LenW-1:0];
    r.last         = is_last;
    return r;
  endfunction

  // Update the mirror for one accepted request and queue up what it should return.
  task automatic queue_outcome(input mqf_pkg::req_t r);
    int unsigned q;
    int unsigned slot;
    q = r.queue_id;
    case (r.command)
      mqf_pkg::CMD_LEN: begin
        for (int i = 0; i < NUM_QUEUES; i++)
          owed_results.push_back(make_result(mqf_pkg::ST_OK, i, '0, 1'b0, fill_mirror[i],
                                             i == NUM_QUEUES - 1));
      end
      mqf_pkg::CMD_ENQ, mqf_pkg::CMD_DEQ: begin
        if (q >= NUM_QUEUES) begin
          owed_results.push_back(make_result(mqf_pkg::ST_BADID, q, '0, 1'b0, 0, 1'b1));
        end else if (r.command == mqf_pkg::CMD_ENQ) begin
          if (fill_mirror[q] >= QUEUE_DEPTH) begin
            owed_results.push_back(make_result(mqf_pkg::ST_FULL, q, '0, 1'b0,
                                               fill_mirror[q], 1'b1));
          end else begin
            slot = (head_mirror[q] + fill_mirror[q]) % QUEUE_DEPTH;
            data_mirror[q * QUEUE_DEPTH + slot]   = r.entry_data;
            urgent_mirror[q * QUEUE_DEPTH + slot] = r.entry_urgent;
            fill_mirror[q]++;
            owed_results.push_back(make_result(mqf_pkg::ST_OK, q, '0, 1'b0,
                                               fill_mirror[q], 1'b1));
          end
        end else if (fill_mirror[q] == 0) begin
          owed_results.push_back(make_result(mqf_pkg::ST_EMPTY, q, '0, 1'b0, 0, 1'b1));
        end else begin
          slot = head_mirror[q];
          head_mirror[q] = (slot + 1) % QUEUE_DEPTH;
          fill_mirror[q]--;
          owed_results.push_back(make_result(mqf_pkg::ST_OK, q,
                                             data_mirror[q * QUEUE_DEPTH + slot],
                                             urgent_mirror[q * QUEUE_DEPTH + slot],
                                             fill_mirror[q], 1'b1));
        end
      end
      // The unused command code is dropped without a result.
      default: ;
    endcase
  endtask

  // Compare one result from the block with the oldest owed one.
  task automatic check_result(input mqf_pkg::res_t got);
    mqf_pkg::res_t want;
    if (owed_results.size() == 0) begin
      $display("%0t: unexpected result: status %0d queue %0d data %h urgent %0d length %0d last %0d",
               $time, got.status, got.out_queue, got.out_data, got.out_urgent,
               got.queue_length, got.last);
      fail_count_o++;
    end else begin
      want = owed_results.pop_front();
      // Every field is compared; X or Z on any of them also counts as wrong.
      if (got !== want) begin
        $display("%0t: expected status %0d queue %0d data %h urgent %0d length %0d last %0d",
                 $time, want.status, want.out_queue, want.out_data, want.out_urgent,
                 want.queue_length, want.last);
        $display("%0t: actual   status %0d queue %0d data %h urgent %0d length %0d last %0d",
                 $time, got.status, got.out_queue, got.out_data, got.out_urgent,
                 got.queue_length, got.last);
        fail_count_o++;
      end
    end
  endtask

  initial begin
    fail_count_o  = 0;
    outstanding_o = 0;
  end

  // Results are checked before the request of the same edge is taken in,
  // since a result always belongs to an earlier request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_mirror[i] = 0;
        fill_mirror[i] = 0;
      end
      owed_results.delete();
    end else begin
      if (res_strobe_i) check_result(res_i);
      if (start_i && !busy_i) queue_outcome(req_i);
    end
    outstanding_o = owed_results.size();
  end

endmodule

// ===== tb/multi_queue_fifo_tb.sv =====
// Top of the multi-queue FIFO testbench: clock, reset, request stimulus and verdict.
// Depends on mqf_pkg, multi_queue_fifo and multi_queue_fifo_checker.
`timescale 1ns / 1ps

module multi_queue_fifo_tb;

  localparam int unsigned NumQueues      = 4;
  localparam int unsigned QueueDepth     = 16;
  localparam int unsigned RequestsPerRun = 430;
  localparam int unsigned WatchdogLimit  = 2000;
  localparam int unsigned DrainCycles    = 10;
  // Command code with no meaning; the block drops it.
  localparam logic [mqf_pkg::CmdW-1:0] CmdUnused = 2'd3;

  logic          clk_i  = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start  = 1'b0;
  mqf_pkg::req_t req_i  = '0;
  wire           busy;
  wire           res_strobe_o;
  mqf_pkg::res_t res_o;
  int            fail_count;
  int            outstanding;
  int unsigned   idle_pct     = 0;
  int unsigned   quiet_cycles = 0;

  always #6 clk_i = ~clk_i;

  multi_queue_fifo #(
    .NUM_QUEUES (NumQueues),
    .QUEUE_DEPTH(QueueDepth)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o)
  );

  multi_queue_fifo_checker #(
    .NUM_QUEUES (NumQueues),
    .QUEUE_DEPTH(QueueDepth)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req_i),
    .res_strobe_i (res_strobe_o),
    .res_i        (res_o),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding)
  );

  function automatic logic [mqf_pkg::DataW-1:0] random_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic mqf_pkg::req_t make_request(logic [mqf_pkg::CmdW-1:0] cmd,
                                                 logic [mqf_pkg::QidW-1:0] qid,
                                                 logic [mqf_pkg::DataW-1:0] d, logic u);
    mqf_pkg::req_t r;
    r.command      = cmd;
    r.queue_id     = qid;
    r.entry_data   = d;
    r.entry_urgent = u;
    return r;
  endfunction

  // Present one request at a falling edge, after random idle cycles with start low
  // and junk on the payload, and hold it until a rising edge finds busy low.
  task automatic send_request(input mqf_pkg::req_t r);
    logic [95:0] junk;
    while ($urandom_range(99) < idle_pct) begin
      junk = {$urandom, $urandom, $urandom};
      @(negedge clk_i);
      start <= 1'b0;
      req_i <= mqf_pkg::req_t'(junk[$bits(mqf_pkg::req_t)-1:0]);
    end
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
  endtask

  // Watchdog: end the run if neither a request nor a result moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || res_strobe_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("multi_queue_fifo test failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned                 phase_idle [3] = '{0, 64, 11};
    int unsigned                 counted;
    int unsigned                 burst;
    int unsigned                 pick;
    logic [mqf_pkg::CmdW-1:0]    cmd;
    logic [mqf_pkg::QidW-1:0]    qid;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests: empty dequeue, data extremes, bad ids, the unused code,
    // length reports and one queue filled past its depth.
    send_request(make_request(mqf_pkg::CMD_DEQ, 3'd0, '0, 1'b0));
    send_request(make_request(mqf_pkg::CMD_ENQ, 3'd0, '0, 1'b0));
    send_request(make_request(mqf_pkg::CMD_ENQ, 3'd0, '1, 1'b1));
    send_request(make_request(mqf_pkg::CMD_ENQ, 3'd4, '1, 1'b1));
    send_request(make_request(mqf_pkg::CMD_DEQ, 3'd7, '0, 1'b0));
    send_request(make_request(CmdUnused, 3'd1, '1, 1'b1));
    send_request(make_request(mqf_pkg::CMD_LEN, 3'd7, '1, 1'b1));
    send_request(make_request(mqf_pkg::CMD_DEQ, 3'd0, '1, 1'b1));
    send_request(make_request(mqf_pkg::CMD_DEQ, 3'd0, '0, 1'b0));
    for (int i = 0; i < QueueDepth; i++)
      send_request(make_request(mqf_pkg::CMD_ENQ, mqf_pkg::QidW'(NumQueues - 1),
                                random_word(), 1'($urandom_range(1))));
    send_request(make_request(mqf_pkg::CMD_ENQ, mqf_pkg::QidW'(NumQueues - 1), '1, 1'b1));
    send_request(make_request(mqf_pkg::CMD_LEN, 3'd0, '0, 1'b0));

    // Random requests in phases of different sender idling. Bursts on one queue
    // can drive it to full or empty; single requests mix commands and queue ids.
    foreach (phase_idle[p]) begin
      idle_pct = phase_idle[p];
      counted  = 0;
      while (counted < RequestsPerRun / 3) begin
        pick = $urandom_range(9);
        if (pick < 6) begin
          pick = $urandom_range(15);
          cmd  = pick < 7 ? mqf_pkg::CMD_ENQ : pick < 13 ? mqf_pkg::CMD_DEQ :
                 pick < 15 ? mqf_pkg::CMD_LEN : CmdUnused;
          qid  = $urandom_range(9) == 0 ? mqf_pkg::QidW'($urandom_range(7))
                                        : mqf_pkg::QidW'($urandom_range(NumQueues - 1));
          send_request(make_request(cmd, qid, random_word(), 1'($urandom_range(1))));
          if (cmd != CmdUnused) counted++;
        end else begin
          cmd   = pick < 8 ? mqf_pkg::CMD_ENQ : mqf_pkg::CMD_DEQ;
          qid   = mqf_pkg::QidW'($urandom_range(NumQueues - 1));
          burst = $urandom_range(QueueDepth + 2, 1);
          repeat (burst)
            send_request(make_request(cmd, qid, random_word(), 1'($urandom_range(1))));
          counted += burst;
        end
      end
    end

    @(negedge clk_i);
    start <= 1'b0;

    // Wait for every owed result, then let the bench run on to catch anything stray.
    while (outstanding != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("multi_queue_fifo test passed");
    end else begin
      $display("multi_queue_fifo test failed");
    end
    $finish;
  end

endmodule
